### hdl/ipfc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ipfc_pkg
// Shared types and constants of the incremental PI force controller.
// ----------------------------------------------------------------------------
package ipfc_pkg;

    localparam int DEF_DATA_WIDTH    = 32;
    localparam int DEF_FRACTION_BITS = 16;

    localparam int GAIN_W    = 32;
    localparam int DT_W      = 16;
    localparam int CFG_IDX_W = 4;

    localparam logic [CFG_IDX_W-1:0] CFG_KP = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_KI = CFG_IDX_W'(1);

    localparam logic [GAIN_W-1:0] KP_RESET = GAIN_W'(24248320);
    localparam logic [GAIN_W-1:0] KI_RESET = GAIN_W'(229376);

    localparam int SUM_W     = 66;
    localparam int T_W       = 64;
    localparam int CAP_SHIFT = 62;
    localparam int HI_SHIFT  = 64;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ERR,
        ST_DIFF,
        ST_MUL_P,
        ST_ADD_P,
        ST_MUL_I,
        ST_MUL_T,
        ST_ADD_I,
        ST_FIN
    } t_state;

    typedef struct packed {
        logic en;
        logic clear;
    } t_mac_ctl;

endpackage
`default_nettype wire

### hdl/ipfc_mac.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ipfc_mac
// Shared multiply-accumulate unit: acc = (acc << 16) + a * digit per enabled step, or a * digit on clear.
// ----------------------------------------------------------------------------
module ipfc_mac import ipfc_pkg::*; #(
    parameter int A_W = GAIN_W + DEF_DATA_WIDTH
) (
    input  wire logic                 i_clk,
    input  wire t_mac_ctl             i_ctl,
    input  wire logic [A_W-1:0]       i_a,
    input  wire logic [DT_W-1:0]      i_digit,
    output logic      [A_W+DT_W-1:0]  o_acc
);

    localparam int ACC_W = A_W + DT_W;

    logic [ACC_W-1:0] r_acc;
    logic [ACC_W-1:0] n_acc;
    logic [ACC_W-1:0] w_prod;
    logic [ACC_W-1:0] w_base;

    assign w_prod = i_a * i_digit;
    assign w_base = i_ctl.clear ? '0 : (r_acc << DT_W);
    assign n_acc  = w_base + w_prod;

    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            r_acc <= n_acc;
        end
    end

    assign o_acc = r_acc;

endmodule
`default_nettype wire

### hdl/ipfc_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ipfc_div
// Restoring divider, one quotient bit per cycle, for (num << F) / den.
// ----------------------------------------------------------------------------
module ipfc_div import ipfc_pkg::*; #(
    parameter int DATA_WIDTH    = DEF_DATA_WIDTH,
    parameter int FRACTION_BITS = DEF_FRACTION_BITS
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  i_start,
    input  wire logic [DATA_WIDTH:0]                   i_num,
    input  wire logic [DATA_WIDTH-1:0]                 i_den,
    output logic                                       o_busy,
    output logic      [DATA_WIDTH+FRACTION_BITS:0]     o_quo
);

    localparam int NB    = DATA_WIDTH + FRACTION_BITS + 1;
    localparam int CNT_W = $clog2(NB + 1);

    logic                  r_busy;
    logic [CNT_W-1:0]      r_cnt;
    logic [DATA_WIDTH-1:0] r_rem;
    logic [DATA_WIDTH-1:0] r_den;
    logic [NB-1:0]         r_quo;

    logic [DATA_WIDTH:0]   w_r2;
    logic [DATA_WIDTH+1:0] w_sub;
    logic                  w_take;

    assign w_r2   = {r_rem, r_quo[NB-1]};
    assign w_sub  = {1'b0, w_r2} - {2'b00, r_den};
    assign w_take = ~w_sub[DATA_WIDTH+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CNT_W'(NB);
        end else if (r_busy) begin
            r_cnt <= r_cnt - CNT_W'(1);
            if (r_cnt == CNT_W'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_den <= i_den;
            r_quo <= {i_num, {FRACTION_BITS{1'b0}}};
        end else if (r_busy) begin
            r_rem <= w_take ? w_sub[DATA_WIDTH-1:0] : w_r2[DATA_WIDTH-1:0];
            r_quo <= {r_quo[NB-2:0], w_take};
        end
    end

    assign o_busy = r_busy;
    assign o_quo  = r_quo;

endmodule
`default_nettype wire

### hdl/incremental_pi_force_controller_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// incremental_pi_force_controller_core
// Velocity-form PI force controller with relative position error output.
// ----------------------------------------------------------------------------
// Channel   Direction  Beat contents
// s         in         tdata: position_measured, position_target,
//                      force_measured, force_target, time_step; tuser: restart
// m         out        tdata: position_command, force_command,
//                      velocity_command, relative_position_error;
//                      tuser: divide_by_zero
// cfg       in         index 0 proportional_gain, index 1 integral_gain
//
// A beat is accepted only while the sequence is idle, and the sequence ends
// once the divider, which retires one quotient bit per cycle, is done and the
// output register is free. The shared multiplier finishes well before the divider.
// Reset clears the gate, the accumulator and the stored error, and it loads
// the default gains.
// A result waiting on the m side does not block acceptance of the next beat.
// ----------------------------------------------------------------------------
module incremental_pi_force_controller_core import ipfc_pkg::*; #(
    parameter int DATA_WIDTH    = DEF_DATA_WIDTH,
    parameter int FRACTION_BITS = DEF_FRACTION_BITS,
    localparam int IN_TD_W  = ((4 * DATA_WIDTH + DT_W + 7) / 8) * 8,
    localparam int OUT_TD_W = ((4 * DATA_WIDTH + 7) / 8) * 8
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_s_tvalid,
    output logic                      o_s_tready,
    // position_measured, position_target, force_measured, force_target, time_step
    input  wire logic [IN_TD_W-1:0]   i_s_tdata,
    // restart
    input  wire logic [0:0]           i_s_tuser,
    output logic                      o_m_tvalid,
    input  wire logic                 i_m_tready,
    // position_command, force_command, velocity_command, relative_position_error
    output logic      [OUT_TD_W-1:0]  o_m_tdata,
    // divide_by_zero
    output logic      [0:0]           o_m_tuser,
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [GAIN_W-1:0]    i_cfg_data
);

    localparam int W     = DATA_WIDTH;
    localparam int F     = FRACTION_BITS;
    localparam int A_W   = GAIN_W + W;
    localparam int ACC_W = A_W + DT_W;
    localparam int NB    = W + F + 1;
    localparam int NDIG  = (W + 1 + DT_W - 1) / DT_W;
    localparam int MOP_W = NDIG * DT_W;
    localparam int CNT_W = $clog2(NDIG);

    localparam logic signed [SUM_W-1:0] L_VMAX =
        $signed((SUM_W'(1) << (W - 1)) - SUM_W'(1));
    localparam logic signed [SUM_W-1:0] L_VMIN = -L_VMAX - SUM_W'(1);
    localparam logic [W-1:0] VMAX = L_VMAX[W-1:0];
    localparam logic [W-1:0] VMIN = L_VMIN[W-1:0];

    function automatic logic signed [W-1:0] f_sat(input logic signed [SUM_W-1:0] x);
        logic [W-1:0] y;
        if (x > L_VMAX) begin
            y = VMAX;
        end else if (x < L_VMIN) begin
            y = VMIN;
        end else begin
            y = x[W-1:0];
        end
        return $signed(y);
    endfunction

    function automatic logic signed [T_W-1:0] f_scale(input logic [ACC_W-1:0] m,
                                                      input int unsigned s,
                                                      input logic neg);
        logic [ACC_W-1:0] q;
        logic [ACC_W-1:0] cap_v;
        logic             rem;
        logic             hi_nz;
        cap_v = ACC_W'(1) << CAP_SHIFT;
        hi_nz = (m >> (HI_SHIFT + s)) != '0;
        q     = m >> s;
        rem   = (m & ((ACC_W'(1) << s) - ACC_W'(1))) != '0;
        if (hi_nz) begin
            q   = cap_v;
            rem = 1'b0;
        end else if (q > cap_v) begin
            q = cap_v;
        end
        if (neg) begin
            return -$signed(q[T_W-1:0] + T_W'(rem));
        end
        return $signed(q[T_W-1:0]);
    endfunction

    t_state r_state;
    t_state n_state;

    logic [GAIN_W-1:0] r_kp;
    logic [GAIN_W-1:0] r_ki;

    logic                  r_gate;
    logic signed [W-1:0]   r_vacc;
    logic signed [W-1:0]   r_prev;
    logic signed [W-1:0]   r_vtmp;
    logic signed [W-1:0]   r_e;
    logic                  r_eneg;
    logic                  r_dneg;
    logic signed [W-1:0]   r_pos;
    logic signed [W-1:0]   r_pos_t;
    logic signed [W-1:0]   r_frc;
    logic signed [W-1:0]   r_fcmd;
    logic [DT_W-1:0]       r_dt;
    logic [MOP_W-1:0]      r_mop;
    logic [CNT_W-1:0]      r_cnt;
    logic                  r_dz;
    logic                  r_qneg;
    logic                  r_diff_neg;
    logic                  r_diff_zero;

    logic                  r_out_valid;
    logic [W-1:0]          r_o_pos;
    logic [W-1:0]          r_o_frc;
    logic [W-1:0]          r_o_vel;
    logic [W-1:0]          r_o_rel;
    logic                  r_o_dz;

    t_mac_ctl              w_mac_ctl;
    logic [A_W-1:0]        w_mac_a;
    logic [DT_W-1:0]       w_mac_digit;
    logic [ACC_W-1:0]      w_acc;

    logic                  w_div_start;
    logic                  w_div_busy;
    logic [NB-1:0]         w_quo;

    logic                  w_in_acc;
    logic                  w_load_out;
    logic                  w_gate;
    logic signed [W-1:0]   w_e;
    logic signed [W:0]     w_d;
    logic [W:0]            w_dmag;
    logic [W-1:0]          w_emag;
    logic signed [W:0]     w_pdiff;
    logic [W:0]            w_pdiff_mag;
    logic [W-1:0]          w_pos_t_mag;
    logic signed [T_W-1:0] w_t1;
    logic signed [T_W-1:0] w_t2;
    logic                  w_qovf;
    logic [W-1:0]          w_rel;

    assign o_cfg_ready = 1'b1;
    assign o_s_tready  = (r_state == ST_IDLE);
    assign w_in_acc    = i_s_tvalid && o_s_tready;
    assign w_gate      = r_gate | i_s_tuser[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kp <= KP_RESET;
            r_ki <= KI_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            if (i_cfg_index == CFG_KP) begin
                r_kp <= i_cfg_data;
            end else if (i_cfg_index == CFG_KI) begin
                r_ki <= i_cfg_data;
            end
        end
    end

    always_comb begin
        n_state     = r_state;
        w_mac_ctl   = '0;
        w_div_start = 1'b0;
        w_load_out  = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (w_in_acc) begin
                    n_state = ST_ERR;
                end
            end
            ST_ERR: begin
                w_div_start = 1'b1;
                n_state     = ST_DIFF;
            end
            ST_DIFF: begin
                n_state = ST_MUL_P;
            end
            ST_MUL_P: begin
                w_mac_ctl.en    = 1'b1;
                w_mac_ctl.clear = (r_cnt == CNT_W'(NDIG - 1));
                if (r_cnt == '0) begin
                    n_state = ST_ADD_P;
                end
            end
            ST_ADD_P: begin
                n_state = ST_MUL_I;
            end
            ST_MUL_I: begin
                w_mac_ctl.en    = 1'b1;
                w_mac_ctl.clear = (r_cnt == CNT_W'(NDIG - 1));
                if (r_cnt == '0) begin
                    n_state = ST_MUL_T;
                end
            end
            ST_MUL_T: begin
                w_mac_ctl.en    = 1'b1;
                w_mac_ctl.clear = 1'b1;
                n_state         = ST_ADD_I;
            end
            ST_ADD_I: begin
                n_state = ST_FIN;
            end
            ST_FIN: begin
                if (!w_div_busy && (!r_out_valid || i_m_tready)) begin
                    w_load_out = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign w_e     = f_sat(SUM_W'(r_fcmd) - SUM_W'(r_frc));
    assign w_d     = (W+1)'(r_e) - (W+1)'(r_prev);
    assign w_dmag  = w_d[W] ? (W+1)'(-w_d) : (W+1)'(w_d);
    assign w_emag  = r_e[W-1] ? W'(-r_e) : W'(r_e);
    assign w_pdiff = (W+1)'(r_pos) - (W+1)'(r_pos_t);
    assign w_pdiff_mag = w_pdiff[W] ? (W+1)'(-w_pdiff) : (W+1)'(w_pdiff);
    assign w_pos_t_mag = r_pos_t[W-1] ? W'(-r_pos_t) : W'(r_pos_t);

    assign w_t1 = f_scale(w_acc, F, r_dneg);
    assign w_t2 = f_scale(w_acc, 2 * F, r_eneg);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gate <= 1'b0;
            r_vacc <= '0;
            r_prev <= '0;
        end else begin
            if (w_in_acc) begin
                r_gate <= w_gate;
            end
            if (r_state == ST_DIFF) begin
                r_prev <= r_e;
            end
            if (r_state == ST_ADD_I) begin
                r_vacc <= f_sat(SUM_W'(r_vtmp) + SUM_W'(w_t2));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_pos   <= $signed(i_s_tdata[W-1:0]);
            r_pos_t <= $signed(i_s_tdata[2*W-1:W]);
            r_frc   <= $signed(i_s_tdata[3*W-1:2*W]);
            r_fcmd  <= w_gate ? $signed(i_s_tdata[4*W-1:3*W]) : '0;
            r_dt    <= i_s_tdata[4*W+DT_W-1:4*W];
        end
        if (r_state == ST_ERR) begin
            r_e         <= w_e;
            r_dz        <= (r_pos_t == '0);
            r_qneg      <= w_pdiff[W] ^ r_pos_t[W-1];
            r_diff_neg  <= w_pdiff[W];
            r_diff_zero <= (w_pdiff == '0);
        end
        if (r_state == ST_DIFF) begin
            r_dneg <= w_d[W];
            r_eneg <= r_e[W-1];
            r_mop  <= MOP_W'(w_dmag);
            r_cnt  <= CNT_W'(NDIG - 1);
        end
        if (r_state == ST_MUL_P || r_state == ST_MUL_I) begin
            r_mop <= r_mop << DT_W;
            r_cnt <= r_cnt - CNT_W'(1);
        end
        if (r_state == ST_ADD_P) begin
            r_vtmp <= f_sat(SUM_W'(r_vacc) + SUM_W'(w_t1));
            r_mop  <= MOP_W'(w_emag);
            r_cnt  <= CNT_W'(NDIG - 1);
        end
    end

    always_comb begin
        unique case (r_state)
            ST_MUL_P: w_mac_a = A_W'(r_kp);
            ST_MUL_I: w_mac_a = A_W'(r_ki);
            default:  w_mac_a = w_acc[A_W-1:0];
        endcase
    end

    assign w_mac_digit = (r_state == ST_MUL_T) ? r_dt : r_mop[MOP_W-1 -: DT_W];

    ipfc_mac #(
        .A_W (A_W)
    ) u_mac (
        .i_clk   (i_clk),
        .i_ctl   (w_mac_ctl),
        .i_a     (w_mac_a),
        .i_digit (w_mac_digit),
        .o_acc   (w_acc)
    );

    ipfc_div #(
        .DATA_WIDTH    (W),
        .FRACTION_BITS (F)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_pdiff_mag),
        .i_den   (w_pos_t_mag),
        .o_busy  (w_div_busy),
        .o_quo   (w_quo)
    );

    assign w_qovf = |w_quo[NB-1:W-1];

    always_comb begin
        if (r_dz) begin
            w_rel = r_diff_zero ? '0 : (r_diff_neg ? VMIN : VMAX);
        end else if (r_qneg) begin
            w_rel = w_qovf ? VMIN : W'(-w_quo[W-1:0]);
        end else begin
            w_rel = w_qovf ? VMAX : w_quo[W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load_out) begin
            r_o_pos <= r_pos_t;
            r_o_frc <= r_fcmd;
            r_o_vel <= r_vacc;
            r_o_rel <= w_rel;
            r_o_dz  <= r_dz;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = OUT_TD_W'({r_o_rel, r_o_vel, r_o_frc, r_o_pos});
    assign o_m_tuser  = r_o_dz;

    a_idle_div_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> !w_div_busy)
        else $error("divider still busy while the block takes a new beat");

    a_gate_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_gate |=> r_gate)
        else $error("force gate dropped without reset");

    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> (r_state == ST_ERR))
        else $error("accepted beat did not start the sequence");

    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load_out |-> (!r_out_valid || i_m_tready))
        else $error("result overwritten before it was taken");

endmodule
`default_nettype wire
